// ===== design/gffp_pkg.sv =====
// ----------------------------------------------------------------------------
// gffp_pkg - shared definitions for the grid flow-field planner
// Grid limits, cost codes, request and register codes, sequencer states and
// the request/result bundles of the direction unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gffp_pkg;

    // grid limits
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int ZW    = $clog2(MAX_HEIGHT);
    localparam int EW    = $clog2(MAX_WIDTH + 1);
    localparam int EH    = $clog2(MAX_HEIGHT + 1);
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int CNTW  = $clog2(CELLS + 1);
    localparam int QW    = XW + ZW;

    // data widths
    localparam int CW = 8;
    localparam int BW = 32;
    localparam int DW = 16;
    localparam int GW = BW + 1;

    // cost codes
    localparam logic [CW-1:0] COST_WALL  = 8'd255;
    localparam logic [CW-1:0] COST_RESET = 8'd1;
    localparam logic [BW-1:0] COST_UNREACH = 32'hFFFF_FFFF;
    localparam logic [BW-1:0] COST_SAT     = 32'hFFFF_FFFE;
    localparam logic [8:0] MOVE_STRAIGHT = 9'd256;
    localparam logic [8:0] MOVE_DIAG     = 9'd362;

    // request codes
    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_SOLVE = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    // configuration registers
    localparam int CFG_IW = 4;
    localparam int CFG_DW = 7;
    localparam logic [CFG_IW-1:0] CFG_GRID_WIDTH  = 4'd0;
    localparam logic [CFG_IW-1:0] CFG_GRID_HEIGHT = 4'd1;
    localparam logic [CFG_DW-1:0] GRID_W_RESET = 7'd64;
    localparam logic [CFG_DW-1:0] GRID_H_RESET = 7'd64;

    // main sequencer
    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_QUERY,
        ST_CLEAR,
        ST_SEED,
        ST_POP,
        ST_POPW,
        ST_CUR,
        ST_NB_A,
        ST_NB_B,
        ST_NB_C,
        ST_NB_D,
        ST_NB_E,
        ST_DIR_CELL,
        ST_DIR_WALL,
        ST_DIR_RD,
        ST_DIR_CALC,
        ST_DIR_WAIT,
        ST_RESP
    } state_t;

    // direction unit sequencer
    typedef enum logic [3:0] {
        U_IDLE,
        U_SHIFT,
        U_SQ_X,
        U_SQ_Z,
        U_SUM,
        U_START,
        U_DIV,
        U_SQRT,
        U_DONE
    } mag_state_t;

    typedef struct packed {
        logic                 start;
        logic signed [GW-1:0] gx;
        logic signed [GW-1:0] gz;
    } mag_req_t;

    typedef struct packed {
        logic                 done;
        logic signed [DW-1:0] rx;
        logic signed [DW-1:0] rz;
    } mag_res_t;

    // neighbour step table: four straight steps, then four diagonals
    function automatic logic signed [1:0] step_dx(input logic [2:0] k);
        logic signed [1:0] d;
        case (k)
            3'd0, 3'd1: d = 2'sd0;
            3'd2, 3'd4, 3'd5: d = 2'sd1;
            default: d = -2'sd1;
        endcase
        return d;
    endfunction

    function automatic logic signed [1:0] step_dz(input logic [2:0] k);
        logic signed [1:0] d;
        case (k)
            3'd0, 3'd4, 3'd6: d = 2'sd1;
            3'd2, 3'd3: d = 2'sd0;
            default: d = -2'sd1;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== design/gffp_ram.sv =====
// ----------------------------------------------------------------------------
// gffp_ram - generic simple dual-port ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gffp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/gffp_unit_mag.sv =====
// ----------------------------------------------------------------------------
// gffp_unit_mag - iterative unit-vector unit
// Turns a gradient into a Q1.14 unit direction: normalizing shift, squares
// on one shared multiplier, bit-serial divide and digit-serial square root.
// ----------------------------------------------------------------------------
`default_nettype none

module gffp_unit_mag (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire gffp_pkg::mag_req_t req,
    output gffp_pkg::mag_res_t      res
);

    import gffp_pkg::*;

    mag_state_t state_reg, state_next;
    logic          neg_x_reg, neg_x_next, neg_z_reg, neg_z_next;
    logic [GW-1:0] mx_reg, mx_next, mz_reg, mz_next;
    logic [31:0]   mx2_reg, mx2_next, mz2_reg, mz2_next;
    logic [32:0]   s_reg, s_next;
    logic          comp_reg, comp_next;
    logic          dbit_reg, dbit_next;
    logic [32:0]   rem_reg, rem_next;
    logic [30:0]   q_reg, q_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [31:0]   qsh_reg, qsh_next;
    logic [15:0]   root_reg, root_next;
    logic [17:0]   srem_reg, srem_next;
    logic signed [DW-1:0] rx_reg, rx_next, rz_reg, rz_next;

    logic [15:0] mul_a;
    logic [31:0] mul_p;
    logic [31:0] m2;
    logic        bit_in;
    logic [33:0] div_t;
    logic [19:0] sq_rem;
    logic [19:0] sq_trial;
    logic [15:0] root_new;
    logic [16:0] u_wide;
    logic [DW-1:0] u_mag;
    logic signed [DW-1:0] u_sgn;

    // shared multiplier
    assign mul_a = (state_reg == U_SQ_X) ? mx_reg[15:0] : mz_reg[15:0];
    assign mul_p = 32'(mul_a) * 32'(mul_a);

    always_comb begin
        state_next = state_reg;
        neg_x_next = neg_x_reg;
        neg_z_next = neg_z_reg;
        mx_next    = mx_reg;
        mz_next    = mz_reg;
        mx2_next   = mx2_reg;
        mz2_next   = mz2_reg;
        s_next     = s_reg;
        comp_next  = comp_reg;
        dbit_next  = dbit_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        qsh_next   = qsh_reg;
        root_next  = root_reg;
        srem_next  = srem_reg;
        rx_next    = rx_reg;
        rz_next    = rz_reg;
        m2       = comp_reg ? mz2_reg : mx2_reg;
        bit_in   = (cnt_reg == 5'd0) ? dbit_reg : 1'b0;
        div_t    = {rem_reg, bit_in};
        sq_rem   = {srem_reg, qsh_reg[31:30]};
        sq_trial = {2'b00, root_reg, 2'b01};
        root_new = '0;
        u_wide   = '0;
        u_mag    = '0;
        u_sgn    = '0;
        unique case (state_reg)
            U_IDLE: begin
                if (req.start) begin
                    neg_x_next = req.gx[GW-1];
                    neg_z_next = req.gz[GW-1];
                    mx_next = req.gx[GW-1] ? GW'(-req.gx) : GW'(req.gx);
                    mz_next = req.gz[GW-1] ? GW'(-req.gz) : GW'(req.gz);
                    state_next = U_SHIFT;
                end
            end
            // shift both magnitudes until each fits 16 bits
            U_SHIFT: begin
                if (|(mx_reg[GW-1:16] | mz_reg[GW-1:16])) begin
                    mx_next = mx_reg >> 1;
                    mz_next = mz_reg >> 1;
                end else begin
                    state_next = U_SQ_X;
                end
            end
            U_SQ_X: begin
                mx2_next   = mul_p;
                state_next = U_SQ_Z;
            end
            U_SQ_Z: begin
                mz2_next   = mul_p;
                state_next = U_SUM;
            end
            U_SUM: begin
                s_next = 33'(mx2_reg) + 33'(mz2_reg);
                if ((mx2_reg | mz2_reg) == 32'd0) begin
                    rx_next    = '0;
                    rz_next    = '0;
                    state_next = U_DONE;
                end else begin
                    comp_next  = 1'b0;
                    state_next = U_START;
                end
            end
            // quotient of m^2 * 2^30 by s, high part preloaded
            U_START: begin
                rem_next   = {2'b00, m2[31:1]};
                dbit_next  = m2[0];
                q_next     = '0;
                cnt_next   = '0;
                state_next = U_DIV;
            end
            U_DIV: begin
                if (div_t >= {1'b0, s_reg}) begin
                    rem_next = 33'(div_t - {1'b0, s_reg});
                    q_next   = {q_reg[29:0], 1'b1};
                end else begin
                    rem_next = div_t[32:0];
                    q_next   = {q_reg[29:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd30) begin
                    qsh_next   = {1'b0, q_next};
                    root_next  = '0;
                    srem_next  = '0;
                    cnt_next   = '0;
                    state_next = U_SQRT;
                end
            end
            // integer square root, two radicand bits a step
            U_SQRT: begin
                if (sq_rem >= sq_trial) begin
                    srem_next = 18'(sq_rem - sq_trial);
                    root_new  = {root_reg[14:0], 1'b1};
                end else begin
                    srem_next = sq_rem[17:0];
                    root_new  = {root_reg[14:0], 1'b0};
                end
                root_next = root_new;
                qsh_next  = {qsh_reg[29:0], 2'b00};
                cnt_next  = cnt_reg + 5'd1;
                u_wide    = (17'(root_new) + 17'd1) >> 1;
                u_mag     = u_wide[DW-1:0];
                if (cnt_reg == 5'd15) begin
                    if (comp_reg) begin
                        u_sgn      = neg_z_reg ? -$signed(u_mag) : $signed(u_mag);
                        rz_next    = u_sgn;
                        state_next = U_DONE;
                    end else begin
                        u_sgn      = neg_x_reg ? -$signed(u_mag) : $signed(u_mag);
                        rx_next    = u_sgn;
                        comp_next  = 1'b1;
                        state_next = U_START;
                    end
                end
            end
            U_DONE: begin
                state_next = U_IDLE;
            end
            default: begin
                state_next = U_IDLE;
            end
        endcase
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        neg_x_reg <= neg_x_next;
        neg_z_reg <= neg_z_next;
        mx_reg    <= mx_next;
        mz_reg    <= mz_next;
        mx2_reg   <= mx2_next;
        mz2_reg   <= mz2_next;
        s_reg     <= s_next;
        comp_reg  <= comp_next;
        dbit_reg  <= dbit_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        cnt_reg   <= cnt_next;
        qsh_reg   <= qsh_next;
        root_reg  <= root_next;
        srem_reg  <= srem_next;
        rx_reg    <= rx_next;
        rz_reg    <= rz_next;
    end

    assign res.done = (state_reg == U_DONE);
    assign res.rx   = rx_reg;
    assign res.rz   = rz_reg;

endmodule

`default_nettype wire

// ===== design/grid_flow_field_planner.sv =====
// ----------------------------------------------------------------------------
// grid_flow_field_planner - 8-neighbour flow-field planner
// Cost map, queued relaxation toward a target and per-cell unit directions.
// ----------------------------------------------------------------------------
// After reset the block clears its rams (cost one, unreachable, zero
// direction) before s_ready rises; configuration writes are taken at any
// time. A cost write, an unused request or an out-of-grid write or query
// is answered from the idle state, an in-grid query by way of ST_QUERY, as
// the direction ram has registered reads. A solve holds the input through
// a clearing sweep of the best-cost ram (an out-of-grid solve ends there),
// then the pop states per queued cell and ST_NB_A to ST_NB_E per neighbour,
// paced by the single read port of the cost and best-cost rams, then for
// each non-wall cell reads of its four side costs and, where both side
// pairs allow, the shared direction unit (normalizing shift, two squares on
// one multiplier, a 31-step divide and a 16-step square root per component).
// ----------------------------------------------------------------------------
`default_nettype none

module grid_flow_field_planner (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_req_type,
    input  wire logic [7:0]                    s_cell_x,
    input  wire logic [7:0]                    s_cell_z,
    input  wire logic [7:0]                    s_cell_cost,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_status,
    output logic signed [15:0]                 m_dir_x,
    output logic signed [15:0]                 m_dir_z,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [gffp_pkg::CFG_IW-1:0]   cfg_index,
    input  wire logic [gffp_pkg::CFG_DW-1:0]   cfg_data
);

    import gffp_pkg::*;

    state_t state_reg, state_next;

    logic [CFG_DW-1:0] gw_reg, gh_reg;
    logic [AW-1:0]     sweep_reg, sweep_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_status_reg, m_status_next;
    logic signed [DW-1:0] m_dir_x_reg, m_dir_x_next, m_dir_z_reg, m_dir_z_next;
    logic [XW-1:0]     tx_reg, tx_next;
    logic [ZW-1:0]     tz_reg, tz_next;
    logic              tin_reg, tin_next;
    logic              resp_st_reg, resp_st_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CNTW-1:0]   count_reg, count_next;
    logic [XW-1:0]     cx_reg, cx_next, nx_reg, nx_next, dx_reg, dx_next;
    logic [ZW-1:0]     cz_reg, cz_next, nz_reg, nz_next, dz_reg, dz_next;
    logic [BW-1:0]     cur_reg, cur_next, nb_reg, nb_next;
    logic [2:0]        k_reg, k_next;
    logic [AW-1:0]     di_reg, di_next;
    logic [2:0]        rd_cnt_reg, rd_cnt_next;
    logic [BW-1:0]     we_reg, we_next, ea_reg, ea_next;
    logic [BW-1:0]     no_reg, no_next, so_reg, so_next;

    // ram ports
    logic          cost_we, best_we, dir_we, queue_we, qf_we;
    logic [AW-1:0] cost_waddr, cost_raddr, best_waddr, best_raddr;
    logic [AW-1:0] dir_waddr, dir_raddr, queue_waddr, queue_raddr;
    logic [AW-1:0] qf_waddr, qf_raddr;
    logic [CW-1:0] cost_wdata, cost_rdata;
    logic [BW-1:0] best_wdata, best_rdata;
    logic [DW-1:0] dirx_wdata, dirx_rdata, dirz_wdata, dirz_rdata;
    logic [QW-1:0] queue_wdata, queue_rdata;
    logic          qf_wdata, qf_rdata;

    // effective grid size and cell address unit
    logic [EW-1:0]    eff_w;
    logic [EH-1:0]    eff_h;
    logic [ZW-1:0]    az;
    logic [XW-1:0]    ax;
    logic [ZW+EW-1:0] addr_prod;
    logic [ZW+EW-1:0] addr_sum;
    logic [AW-1:0]    cell_addr;
    logic             in_ok;
    logic             load_out, load_st;
    logic signed [DW-1:0] load_dx, load_dz;

    // neighbour and queue helpers
    logic signed [XW+1:0] nx_s;
    logic signed [ZW+1:0] nz_s;
    logic                 nb_inb;
    logic                 nb_adv, dir_adv;
    logic [16:0]          mv;
    logic [32:0]          nb_sum;
    logic [CNTW:0]        tail_sum;
    logic [AW-1:0]        tail;
    logic [AW:0]          dir_nb_addr;
    logic                 okx, okz;
    logic signed [GW-1:0] gx, gz;

    mag_req_t mreq;
    mag_res_t mres;

    assign eff_w = (gw_reg == '0) ? EW'(1) :
                   (9'(gw_reg) > 9'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(gw_reg);
    assign eff_h = (gh_reg == '0) ? EH'(1) :
                   (9'(gh_reg) > 9'(MAX_HEIGHT)) ? EH'(MAX_HEIGHT) : EH'(gh_reg);

    assign addr_prod = (ZW+EW)'(az) * (ZW+EW)'(eff_w);
    assign addr_sum  = addr_prod + (ZW+EW)'(ax);
    assign cell_addr = addr_sum[AW-1:0];

    assign in_ok = (9'(s_cell_x) < 9'(eff_w)) && (9'(s_cell_z) < 9'(eff_h));

    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign cfg_ready = 1'b1;

    // neighbour coordinates for the current step
    assign nx_s = $signed({2'b00, cx_reg}) + (XW+2)'(step_dx(k_reg));
    assign nz_s = $signed({2'b00, cz_reg}) + (ZW+2)'(step_dz(k_reg));
    assign nb_inb = !nx_s[XW+1] && !nz_s[ZW+1] &&
                    ((XW+1)'(nx_s[XW:0]) < (XW+1)'(eff_w)) &&
                    ((ZW+1)'(nz_s[ZW:0]) < (ZW+1)'(eff_h));

    // queue tail with wrap
    assign tail_sum = (CNTW+1)'(head_reg) + (CNTW+1)'(count_reg);
    assign tail = (tail_sum >= (CNTW+1)'(CELLS)) ? AW'(tail_sum - (CNTW+1)'(CELLS))
                                                : AW'(tail_sum);

    // gradient terms, undefined side pairs give no direction
    assign okx = ((we_reg == COST_UNREACH) == (ea_reg == COST_UNREACH));
    assign okz = ((so_reg == COST_UNREACH) == (no_reg == COST_UNREACH));
    assign gx  = (we_reg == COST_UNREACH) ? '0 :
                 $signed({1'b0, we_reg}) - $signed({1'b0, ea_reg});
    assign gz  = (so_reg == COST_UNREACH) ? '0 :
                 $signed({1'b0, so_reg}) - $signed({1'b0, no_reg});

    // neighbour address in the direction pass: west, east, north, south
    always_comb begin
        case (rd_cnt_reg)
            3'd0: dir_nb_addr = (dx_reg != '0) ? (AW+1)'(di_reg) - (AW+1)'(1)
                                               : (AW+1)'(di_reg);
            3'd1: dir_nb_addr = ((EW)'(dx_reg) + EW'(1) < eff_w) ?
                                (AW+1)'(di_reg) + (AW+1)'(1) : (AW+1)'(di_reg);
            3'd2: dir_nb_addr = ((EH)'(dz_reg) + EH'(1) < eff_h) ?
                                (AW+1)'(di_reg) + (AW+1)'(eff_w) : (AW+1)'(di_reg);
            default: dir_nb_addr = (dz_reg != '0) ?
                                   (AW+1)'(di_reg) - (AW+1)'(eff_w) : (AW+1)'(di_reg);
        endcase
    end

    // main sequencer
    always_comb begin
        state_next   = state_reg;
        sweep_next   = sweep_reg;
        tx_next      = tx_reg;
        tz_next      = tz_reg;
        tin_next     = tin_reg;
        resp_st_next = resp_st_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        cx_next      = cx_reg;
        cz_next      = cz_reg;
        nx_next      = nx_reg;
        nz_next      = nz_reg;
        cur_next     = cur_reg;
        nb_next      = nb_reg;
        k_next       = k_reg;
        dx_next      = dx_reg;
        dz_next      = dz_reg;
        di_next      = di_reg;
        rd_cnt_next  = rd_cnt_reg;
        we_next      = we_reg;
        ea_next      = ea_reg;
        no_next      = no_reg;
        so_next      = so_reg;
        az = '0;
        ax = '0;
        cost_we = 1'b0; cost_waddr = cell_addr; cost_wdata = s_cell_cost;
        cost_raddr = cell_addr;
        best_we = 1'b0; best_waddr = cell_addr; best_wdata = COST_UNREACH;
        best_raddr = cell_addr;
        dir_we = 1'b0; dir_waddr = di_reg; dirx_wdata = '0; dirz_wdata = '0;
        dir_raddr = cell_addr;
        queue_we = 1'b0; queue_waddr = tail; queue_wdata = {nz_reg, nx_reg};
        queue_raddr = head_reg;
        qf_we = 1'b0; qf_waddr = cell_addr; qf_wdata = 1'b0; qf_raddr = cell_addr;
        load_out = 1'b0;
        load_st  = 1'b0;
        load_dx  = '0;
        load_dz  = '0;
        nb_adv   = 1'b0;
        dir_adv  = 1'b0;
        mv       = '0;
        nb_sum   = '0;
        mreq.start = 1'b0;
        mreq.gx    = gx;
        mreq.gz    = gz;
        unique case (state_reg)
            // clearing pass after reset
            ST_INIT: begin
                cost_we = 1'b1; cost_waddr = sweep_reg; cost_wdata = COST_RESET;
                best_we = 1'b1; best_waddr = sweep_reg;
                dir_we  = 1'b1; dir_waddr = sweep_reg;
                qf_we   = 1'b1; qf_waddr = sweep_reg;
                if (sweep_reg == AW'(CELLS - 1)) begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end else begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                az = s_cell_z[ZW-1:0];
                ax = s_cell_x[XW-1:0];
                if (s_valid && s_ready) begin
                    case (req_t'(s_req_type))
                        REQ_WRITE: begin
                            cost_we  = in_ok;
                            load_out = 1'b1;
                            load_st  = !in_ok;
                        end
                        REQ_SOLVE: begin
                            tx_next    = s_cell_x[XW-1:0];
                            tz_next    = s_cell_z[ZW-1:0];
                            tin_next   = in_ok;
                            sweep_next = '0;
                            state_next = ST_CLEAR;
                        end
                        REQ_QUERY: begin
                            if (in_ok) begin
                                state_next = ST_QUERY;
                            end else begin
                                load_out = 1'b1;
                                load_st  = 1'b1;
                            end
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_QUERY: begin
                load_out   = 1'b1;
                load_dx    = $signed(dirx_rdata);
                load_dz    = $signed(dirz_rdata);
                state_next = ST_IDLE;
            end
            // solve: reset best costs and queued flags
            ST_CLEAR: begin
                best_we = 1'b1; best_waddr = sweep_reg;
                qf_we   = 1'b1; qf_waddr = sweep_reg;
                if (sweep_reg == AW'(CELLS - 1)) begin
                    sweep_next = '0;
                    if (tin_reg) begin
                        state_next = ST_SEED;
                    end else begin
                        resp_st_next = 1'b1;
                        state_next   = ST_RESP;
                    end
                end else begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end
            ST_SEED: begin
                az = tz_reg;
                ax = tx_reg;
                best_we = 1'b1; best_wdata = '0;
                qf_we = 1'b1; qf_wdata = 1'b1;
                queue_we = 1'b1; queue_waddr = '0; queue_wdata = {tz_reg, tx_reg};
                head_next  = '0;
                count_next = CNTW'(1);
                state_next = ST_POP;
            end
            ST_POP: begin
                if (count_reg == '0) begin
                    dx_next    = '0;
                    dz_next    = '0;
                    di_next    = '0;
                    state_next = ST_DIR_CELL;
                end else begin
                    state_next = ST_POPW;
                end
            end
            ST_POPW: begin
                az = queue_rdata[QW-1:XW];
                ax = queue_rdata[XW-1:0];
                cz_next = queue_rdata[QW-1:XW];
                cx_next = queue_rdata[XW-1:0];
                qf_we = 1'b1;
                head_next  = (head_reg == AW'(CELLS - 1)) ? '0 : head_reg + AW'(1);
                count_next = count_reg - CNTW'(1);
                state_next = ST_CUR;
            end
            ST_CUR: begin
                cur_next   = best_rdata;
                k_next     = '0;
                state_next = ST_NB_A;
            end
            // bounds first, then the two side cells, then the cell itself
            ST_NB_A: begin
                az = cz_reg;
                ax = nx_s[XW-1:0];
                if (nb_inb) begin
                    nx_next    = nx_s[XW-1:0];
                    nz_next    = nz_s[ZW-1:0];
                    state_next = ST_NB_B;
                end else begin
                    nb_adv = 1'b1;
                end
            end
            ST_NB_B: begin
                az = nz_reg;
                ax = cx_reg;
                if (cost_rdata == COST_WALL) begin
                    nb_adv = 1'b1;
                end else begin
                    state_next = ST_NB_C;
                end
            end
            ST_NB_C: begin
                az = nz_reg;
                ax = nx_reg;
                if (cost_rdata == COST_WALL) begin
                    nb_adv = 1'b1;
                end else begin
                    state_next = ST_NB_D;
                end
            end
            ST_NB_D: begin
                az = nz_reg;
                ax = nx_reg;
                mv = 17'(cost_rdata) * 17'(k_reg[2] ? MOVE_DIAG : MOVE_STRAIGHT);
                nb_sum = 33'(cur_reg) + 33'(mv);
                if (cost_rdata == COST_WALL) begin
                    nb_adv = 1'b1;
                end else begin
                    nb_next = (nb_sum > 33'(COST_SAT)) ? COST_SAT : nb_sum[BW-1:0];
                    state_next = ST_NB_E;
                end
            end
            ST_NB_E: begin
                az = nz_reg;
                ax = nx_reg;
                if (nb_reg < best_rdata) begin
                    best_we = 1'b1; best_wdata = nb_reg;
                    if (!qf_rdata && (count_reg < CNTW'(CELLS))) begin
                        qf_we = 1'b1; qf_wdata = 1'b1;
                        queue_we   = 1'b1;
                        count_next = count_reg + CNTW'(1);
                    end
                end
                nb_adv = 1'b1;
            end
            // direction pass over the grid in row order
            ST_DIR_CELL: begin
                cost_raddr = di_reg;
                state_next = ST_DIR_WALL;
            end
            ST_DIR_WALL: begin
                if (cost_rdata == COST_WALL) begin
                    dir_adv = 1'b1;
                end else begin
                    rd_cnt_next = '0;
                    state_next  = ST_DIR_RD;
                end
            end
            ST_DIR_RD: begin
                best_raddr  = dir_nb_addr[AW-1:0];
                rd_cnt_next = rd_cnt_reg + 3'd1;
                case (rd_cnt_reg)
                    3'd1: we_next = best_rdata;
                    3'd2: ea_next = best_rdata;
                    3'd3: no_next = best_rdata;
                    3'd4: so_next = best_rdata;
                    default: ;
                endcase
                if (rd_cnt_reg == 3'd4) begin
                    state_next = ST_DIR_CALC;
                end
            end
            ST_DIR_CALC: begin
                if (okx && okz) begin
                    mreq.start = 1'b1;
                    state_next = ST_DIR_WAIT;
                end else begin
                    dir_we  = 1'b1;
                    dir_adv = 1'b1;
                end
            end
            ST_DIR_WAIT: begin
                if (mres.done) begin
                    dir_we     = 1'b1;
                    dirx_wdata = mres.rx;
                    dirz_wdata = mres.rz;
                    dir_adv    = 1'b1;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    load_st    = resp_st_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase

        // next neighbour, or next queued cell
        if (nb_adv) begin
            if (k_reg == 3'd7) begin
                state_next = ST_POP;
            end else begin
                k_next     = k_reg + 3'd1;
                state_next = ST_NB_A;
            end
        end

        // next cell of the direction pass
        if (dir_adv) begin
            di_next    = di_reg + AW'(1);
            state_next = ST_DIR_CELL;
            if ((EW)'(dx_reg) + EW'(1) == eff_w) begin
                dx_next = '0;
                if ((EH)'(dz_reg) + EH'(1) == eff_h) begin
                    resp_st_next = 1'b0;
                    state_next   = ST_RESP;
                end else begin
                    dz_next = dz_reg + ZW'(1);
                end
            end else begin
                dx_next = dx_reg + XW'(1);
            end
        end
    end

    // output register
    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_dir_x_next  = m_dir_x_reg;
        m_dir_z_next  = m_dir_z_reg;
        if (load_out) begin
            m_valid_next  = 1'b1;
            m_status_next = load_st;
            m_dir_x_next  = load_dx;
            m_dir_z_next  = load_dz;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
            gw_reg      <= GRID_W_RESET;
            gh_reg      <= GRID_H_RESET;
            head_reg    <= '0;
            count_reg   <= '0;
            k_reg       <= '0;
            rd_cnt_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            m_valid_reg <= m_valid_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            k_reg       <= k_next;
            rd_cnt_reg  <= rd_cnt_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_GRID_WIDTH:  gw_reg <= cfg_data;
                    CFG_GRID_HEIGHT: gh_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_dir_x_reg  <= m_dir_x_next;
        m_dir_z_reg  <= m_dir_z_next;
        tx_reg       <= tx_next;
        tz_reg       <= tz_next;
        tin_reg      <= tin_next;
        resp_st_reg  <= resp_st_next;
        cx_reg       <= cx_next;
        cz_reg       <= cz_next;
        nx_reg       <= nx_next;
        nz_reg       <= nz_next;
        cur_reg      <= cur_next;
        nb_reg       <= nb_next;
        dx_reg       <= dx_next;
        dz_reg       <= dz_next;
        di_reg       <= di_next;
        we_reg       <= we_next;
        ea_reg       <= ea_next;
        no_reg       <= no_next;
        so_reg       <= so_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_dir_x  = m_dir_x_reg;
    assign m_dir_z  = m_dir_z_reg;

    // storage
    gffp_ram #(.WIDTH(CW), .DEPTH(CELLS)) u_cost_ram (
        .aclk(aclk), .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
        .raddr(cost_raddr), .rdata(cost_rdata)
    );

    gffp_ram #(.WIDTH(BW), .DEPTH(CELLS)) u_best_ram (
        .aclk(aclk), .we(best_we), .waddr(best_waddr), .wdata(best_wdata),
        .raddr(best_raddr), .rdata(best_rdata)
    );

    gffp_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_dirx_ram (
        .aclk(aclk), .we(dir_we), .waddr(dir_waddr), .wdata(dirx_wdata),
        .raddr(dir_raddr), .rdata(dirx_rdata)
    );

    gffp_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_dirz_ram (
        .aclk(aclk), .we(dir_we), .waddr(dir_waddr), .wdata(dirz_wdata),
        .raddr(dir_raddr), .rdata(dirz_rdata)
    );

    gffp_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_queue_ram (
        .aclk(aclk), .we(queue_we), .waddr(queue_waddr), .wdata(queue_wdata),
        .raddr(queue_raddr), .rdata(queue_rdata)
    );

    gffp_ram #(.WIDTH(1), .DEPTH(CELLS)) u_qflag_ram (
        .aclk(aclk), .we(qf_we), .waddr(qf_waddr), .wdata(qf_wdata),
        .raddr(qf_raddr), .rdata(qf_rdata)
    );

    // shared direction unit
    gffp_unit_mag u_unit_mag (
        .aclk(aclk),
        .aresetn(aresetn),
        .req(mreq),
        .res(mres)
    );

endmodule

`default_nettype wire
